FILE: hw/rtl/spd_pkg.sv
// Shared types, constants and arithmetic helpers for the stereo ping-pong delay.
package spd_pkg;

	localparam int MAX_FRAMES = 4096;
	localparam int ADDR_W = $clog2(MAX_FRAMES);
	localparam int FILL_W = ADDR_W + 1;
	localparam int DELAY_W = 14;
	localparam int GAIN_W = 17;
	localparam int SAMPLE_W = 24;
	localparam int FRAMES_W = 13;
	localparam int SWAP_W = FILL_W + 1;
	localparam int PROD_W = SAMPLE_W + GAIN_W + 1;
	localparam int RND_W = PROD_W - 16;
	localparam int SUM_W = RND_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 17;
	localparam int OUT_DEPTH = 8;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_CNT_W = OUT_PTR_W + 1;
	localparam int SMALL_FRAMES = 8;

	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
	localparam logic [GAIN_W-1:0] GAIN_STEP = GAIN_W'(66);
	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(2048);
	localparam logic [GAIN_W-1:0] FEEDBACK_RESET = GAIN_W'(32768);
	localparam logic [GAIN_W-1:0] SPREAD_RESET = GAIN_W'(16384);
	localparam logic [FRAMES_W-1:0] FRAMES_SAT = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY    = 2'd0,
		REG_FEEDBACK = 2'd1,
		REG_SPREAD   = 2'd2,
		REG_START    = 2'd3
	} spd_reg_t;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t right;
		sample_t left;
	} frame_t;

	typedef struct packed {
		frame_t            in_frame;
		logic [GAIN_W-1:0] gain_l;
		logic [GAIN_W-1:0] gain_r;
		logic [ADDR_W-1:0] hist_addr;
		logic              hist_ok;
		logic [ADDR_W-1:0] ring_raddr;
		logic              ring_ok;
		logic [ADDR_W-1:0] ring_waddr;
		logic              do_ring;
		logic              self_hit;
	} spd_cmd_t;

	function automatic logic signed [RND_W-1:0] round_q16(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] t;
		t = p + PROD_W'(32768);
		return t[PROD_W-1:16];
	endfunction

	function automatic sample_t sat24(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(8388607)) begin
			return sample_t'(24'h7FFFFF);
		end else if (v < -SUM_W'(8388608)) begin
			return sample_t'(24'h800000);
		end else begin
			return v[SAMPLE_W-1:0];
		end
	endfunction

endpackage

FILE: hw/rtl/stereo_pingpong_delay_core.sv
// An accepted word passes through the registered memory pipeline and the result queue before it is offered.
// Throughput: one word per cycle for delays of 16 samples or more, while input is not held off;
// for shorter delays a word waits until the previous one has written both memories.
// The result queue holds eight words; input is held off while eight words are outstanding.
// Reset clears all control state at once; memory contents are masked by fill counts,
// so no clearing pass runs and the block is ready in the first cycle after reset.
module stereo_pingpong_delay_core import spd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // left_in [23:0], right_in [47:24]
	input  logic                  s_tlast,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,   // left_out [23:0], right_out [47:24]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic                 accept;
	logic                 pop;
	spd_cmd_t             cmd;
	logic [GAIN_W-1:0]    fb_gain;
	logic                 small_delay;
	logic                 res_valid;
	frame_t               res_frame;
	frame_t               head;
	logic                 busy;
	logic [OUT_CNT_W-1:0] pending_q;

	assign s_tready = (pending_q < OUT_CNT_W'(OUT_DEPTH)) && !(small_delay && busy);
	assign accept = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;
	assign m_tdata = head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !pop) begin
			pending_q <= pending_q + OUT_CNT_W'(1);
		end else if (pop && !accept) begin
			pending_q <= pending_q - OUT_CNT_W'(1);
		end
	end

	spd_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cfg_ready   (cfg_ready),
		.accept      (accept),
		.last_frame  (s_tlast),
		.in_frame    (frame_t'(s_tdata)),
		.cmd         (cmd),
		.fb_gain     (fb_gain),
		.small_delay (small_delay)
	);

	spd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue     (accept),
		.cmd       (cmd),
		.fb_gain   (fb_gain),
		.out_valid (res_valid),
		.out_frame (res_frame),
		.busy      (busy)
	);

	spd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_frame),
		.pop       (pop),
		.valid     (m_tvalid),
		.data      (head)
	);

	a_output_owed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != '0)
		else $error("Output word offered with no accepted word outstanding.");

endmodule

FILE: hw/rtl/spd_ctrl.sv
// Control state: configuration registers, pointers, fill counts, gain ramps and side swap.
module spd_ctrl import spd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  cfg_ready,
	input  logic                  accept,
	input  logic                  last_frame,
	input  frame_t                in_frame,
	output spd_cmd_t              cmd,
	output logic [GAIN_W-1:0]     fb_gain,
	output logic                  small_delay
);

	logic [DELAY_W-1:0]  delay_q;
	logic [GAIN_W-1:0]   fb_q;
	logic [GAIN_W-1:0]   spread_q;
	logic                start_side_q;

	logic [ADDR_W-1:0]   rp_q;
	logic [ADDR_W-1:0]   hp_q;
	logic [FILL_W-1:0]   ring_fill_q;
	logic [FILL_W-1:0]   hist_fill_q;
	logic [GAIN_W-1:0]   gain_l_q;
	logic [GAIN_W-1:0]   gain_r_q;
	logic                decay_l_q;
	logic                decay_r_q;
	logic                side_q;
	logic [SWAP_W-1:0]   swap_q;
	logic [FRAMES_W-1:0] seen_q;

	logic [DELAY_W-2:0]  half_c;
	logic [FILL_W-1:0]   frames_c;
	logic [SWAP_W-1:0]   span_c;
	logic [ADDR_W-1:0]   rpw_c;
	logic [ADDR_W-1:0]   hpw_c;
	logic [FILL_W-1:0]   rp_inc_c;
	logic [FILL_W-1:0]   hp_inc_c;
	logic [ADDR_W-1:0]   rp_adv_c;
	logic [ADDR_W-1:0]   hp_next_c;
	logic [FILL_W-1:0]   ring_fill_c;
	logic [FILL_W-1:0]   hist_fill_c;
	logic                do_ring_c;
	logic                side0_c;
	logic                swap_c;

	function automatic logic [GAIN_W-1:0] ramp(input logic [GAIN_W-1:0] g, input logic dec,
			input logic [GAIN_W-1:0] floor_g);
		logic [GAIN_W-1:0] r;
		r = g;
		if (!dec) begin
			if (g < GAIN_ONE) begin
				r = g + GAIN_STEP;
			end
		end else if (g > floor_g) begin
			r = (g > GAIN_STEP) ? g - GAIN_STEP : '0;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign fb_gain = fb_q;

	always_comb begin
		half_c = delay_q[DELAY_W-1:1];
		if (half_c == '0) begin
			frames_c = FILL_W'(1);
		end else if (half_c > (DELAY_W-1)'(MAX_FRAMES)) begin
			frames_c = FILL_W'(MAX_FRAMES);
		end else begin
			frames_c = FILL_W'(half_c);
		end
		span_c = {frames_c, 1'b0};
		small_delay = frames_c < FILL_W'(SMALL_FRAMES);

		rpw_c = ({1'b0, rp_q} >= frames_c) ? '0 : rp_q;
		hpw_c = ({1'b0, hp_q} >= frames_c) ? '0 : hp_q;
		do_ring_c = FILL_W'(seen_q) > frames_c;

		rp_inc_c = {1'b0, rpw_c} + FILL_W'(1);
		if (do_ring_c) begin
			rp_adv_c = (rp_inc_c == frames_c) ? '0 : rp_inc_c[ADDR_W-1:0];
			ring_fill_c = (rp_inc_c > ring_fill_q) ? rp_inc_c : ring_fill_q;
		end else begin
			rp_adv_c = rpw_c;
			ring_fill_c = ring_fill_q;
		end

		hp_inc_c = {1'b0, hpw_c} + FILL_W'(1);
		hp_next_c = (hp_inc_c == frames_c) ? '0 : hp_inc_c[ADDR_W-1:0];
		hist_fill_c = (hp_inc_c > hist_fill_q) ? hp_inc_c : hist_fill_q;

		side0_c = (seen_q == '0) ? start_side_q : side_q;
		swap_c = swap_q > span_c;

		cmd.in_frame = in_frame;
		cmd.gain_l = gain_l_q;
		cmd.gain_r = gain_r_q;
		cmd.hist_addr = hpw_c;
		cmd.hist_ok = {1'b0, hpw_c} < hist_fill_q;
		cmd.ring_raddr = rp_adv_c;
		cmd.ring_ok = {1'b0, rp_adv_c} < ring_fill_c;
		cmd.ring_waddr = rpw_c;
		cmd.do_ring = do_ring_c;
		cmd.self_hit = do_ring_c && (rp_adv_c == rpw_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			fb_q <= FEEDBACK_RESET;
			spread_q <= SPREAD_RESET;
			start_side_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (spd_reg_t'(cfg_index))
				REG_DELAY:    delay_q <= cfg_data[DELAY_W-1:0];
				REG_FEEDBACK: fb_q <= cfg_data[GAIN_W-1:0];
				REG_SPREAD:   spread_q <= cfg_data[GAIN_W-1:0];
				REG_START:    start_side_q <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= '0;
			hp_q <= '0;
			ring_fill_q <= '0;
			hist_fill_q <= '0;
			gain_l_q <= '0;
			gain_r_q <= '0;
			decay_l_q <= 1'b0;
			decay_r_q <= 1'b0;
			side_q <= 1'b0;
			swap_q <= '0;
			seen_q <= '0;
		end else if (accept) begin
			if (last_frame) begin
				rp_q <= '0;
				hp_q <= '0;
				ring_fill_q <= '0;
				hist_fill_q <= '0;
				gain_l_q <= '0;
				gain_r_q <= '0;
				decay_l_q <= 1'b0;
				decay_r_q <= 1'b0;
				side_q <= start_side_q;
				swap_q <= '0;
				seen_q <= '0;
			end else begin
				rp_q <= rp_adv_c;
				hp_q <= hp_next_c;
				ring_fill_q <= ring_fill_c;
				hist_fill_q <= hist_fill_c;
				gain_l_q <= ramp(gain_l_q, decay_l_q, spread_q);
				gain_r_q <= ramp(gain_r_q, decay_r_q, spread_q);
				if (swap_c) begin
					side_q <= ~side0_c;
					decay_l_q <= side0_c;
					decay_r_q <= ~side0_c;
					swap_q <= '0;
				end else begin
					side_q <= side0_c;
					swap_q <= swap_q + SWAP_W'(1);
				end
				if (seen_q != FRAMES_SAT) begin
					seen_q <= seen_q + FRAMES_W'(1);
				end
			end
		end
	end

	a_seen_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last_frame |=> seen_q != '0)
		else $error("Frame count did not advance after an accepted word.");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hist_fill_q <= FILL_W'(MAX_FRAMES) && ring_fill_q <= FILL_W'(MAX_FRAMES))
		else $error("Fill count exceeds the memory depth.");

endmodule

FILE: hw/rtl/spd_dp.sv
// Memory pipeline: history and echo ring memories, feedback and output multipliers.
module spd_dp import spd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              issue,
	input  spd_cmd_t          cmd,
	input  logic [GAIN_W-1:0] fb_gain,
	output logic              out_valid,
	output frame_t            out_frame,
	output logic              busy
);

	frame_t hist_mem [MAX_FRAMES];
	frame_t ring_mem [MAX_FRAMES];

	frame_t   hist_rd_q;
	frame_t   ring_rd_q;

	logic     v_s1;
	spd_cmd_t cmd_s1;

	logic                     v_s2;
	logic signed [PROD_W-1:0] prod_l_s2;
	logic signed [PROD_W-1:0] prod_r_s2;
	frame_t                   echo_s2;
	frame_t                   in_s2;
	logic [ADDR_W-1:0]        ring_waddr_s2;
	logic [ADDR_W-1:0]        hist_addr_s2;
	logic                     do_ring_s2;
	logic                     self_hit_s2;

	logic              v_s3;
	frame_t            echo_s3;
	frame_t            in_s3;
	logic [ADDR_W-1:0] hist_addr_s3;

	logic                     v_s4;
	logic signed [PROD_W-1:0] prod_l_s4;
	logic signed [PROD_W-1:0] prod_r_s4;
	frame_t                   in_s4;
	logic [ADDR_W-1:0]        hist_addr_s4;

	sample_t                  hist_l_c;
	sample_t                  hist_r_c;
	logic signed [PROD_W-1:0] prod_l_c;
	logic signed [PROD_W-1:0] prod_r_c;
	logic signed [RND_W-1:0]  rnd_l_c;
	logic signed [RND_W-1:0]  rnd_r_c;
	frame_t                   ring_wdata_c;
	frame_t                   echo_sel_c;
	logic signed [PROD_W-1:0] echo_l_c;
	logic signed [PROD_W-1:0] echo_r_c;
	logic signed [RND_W-1:0]  erd_l_c;
	logic signed [RND_W-1:0]  erd_r_c;
	frame_t                   out_c;

	always_ff @(posedge clk) begin
		if (issue) begin
			hist_rd_q <= hist_mem[cmd.hist_addr];
		end
		if (v_s4) begin
			hist_mem[hist_addr_s4] <= out_c;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			ring_rd_q <= ring_mem[cmd.ring_raddr];
		end
		if (v_s2 && do_ring_s2) begin
			ring_mem[ring_waddr_s2] <= ring_wdata_c;
		end
	end

	always_comb begin
		hist_l_c = cmd_s1.hist_ok ? hist_rd_q.left : '0;
		hist_r_c = cmd_s1.hist_ok ? hist_rd_q.right : '0;
		prod_l_c = hist_l_c * $signed({1'b0, cmd_s1.gain_l});
		prod_r_c = hist_r_c * $signed({1'b0, cmd_s1.gain_r});

		rnd_l_c = round_q16(prod_l_s2);
		rnd_r_c = round_q16(prod_r_s2);
		ring_wdata_c.left = sat24({rnd_l_c[RND_W-1], rnd_l_c});
		ring_wdata_c.right = sat24({rnd_r_c[RND_W-1], rnd_r_c});
		echo_sel_c = self_hit_s2 ? ring_wdata_c : echo_s2;

		echo_l_c = echo_s3.left * $signed({1'b0, fb_gain});
		echo_r_c = echo_s3.right * $signed({1'b0, fb_gain});

		erd_l_c = round_q16(prod_l_s4);
		erd_r_c = round_q16(prod_r_s4);
		out_c.left = sat24({{(SUM_W-SAMPLE_W){in_s4.left[SAMPLE_W-1]}}, in_s4.left}
			+ {erd_l_c[RND_W-1], erd_l_c});
		out_c.right = sat24({{(SUM_W-SAMPLE_W){in_s4.right[SAMPLE_W-1]}}, in_s4.right}
			+ {erd_r_c[RND_W-1], erd_r_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_s1 <= cmd;
		end
		prod_l_s2 <= prod_l_c;
		prod_r_s2 <= prod_r_c;
		echo_s2 <= cmd_s1.ring_ok ? ring_rd_q : '0;
		in_s2 <= cmd_s1.in_frame;
		ring_waddr_s2 <= cmd_s1.ring_waddr;
		hist_addr_s2 <= cmd_s1.hist_addr;
		do_ring_s2 <= cmd_s1.do_ring;
		self_hit_s2 <= cmd_s1.self_hit;

		echo_s3 <= echo_sel_c;
		in_s3 <= in_s2;
		hist_addr_s3 <= hist_addr_s2;

		prod_l_s4 <= echo_l_c;
		prod_r_s4 <= echo_r_c;
		in_s4 <= in_s3;
		hist_addr_s4 <= hist_addr_s3;
	end

	assign out_valid = v_s4;
	assign out_frame = out_c;
	assign busy = v_s1 | v_s2 | v_s3 | v_s4;

	a_self_hit_writes: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && self_hit_s2 |-> do_ring_s2 && ring_waddr_s2 == cmd_s1.ring_waddr || !v_s1
			|| do_ring_s2)
		else $error("Ring forwarding selected without a ring write.");

	a_pipe_flow: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ##4 v_s4)
		else $error("Issued word did not reach the last pipeline stage.");

endmodule

FILE: hw/rtl/spd_out_fifo.sv
// Result queue between the memory pipeline and the output stream.
module spd_out_fifo import spd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_data,
	input  logic   pop,
	output logic   valid,
	output frame_t data
);

	frame_t                slot_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wr_q;
	logic [OUT_PTR_W-1:0]  rd_q;
	logic [OUT_CNT_W-1:0]  count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + OUT_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + OUT_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - OUT_CNT_W'(1);
			end
		end
	end

	assign valid = count_q != '0;
	assign data = slot_q[rd_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != OUT_CNT_W'(OUT_DEPTH) || pop)
		else $error("Result queue written while full.");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the stereo ping-pong delay core.
module testbench;
	import spd_pkg::*;

	localparam int PEAK_POS = 8388607;
	localparam int PEAK_NEG = -8388608;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD = 400;

	typedef struct {
		bit          is_cfg;
		spd_reg_t    idx;
		int unsigned value;
		int          l;
		int          r;
		bit          last;
		bit          typed;
		frame_t      want;
	} stim_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata = '0;
	logic                  s_tlast = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stereo_pingpong_delay_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	int unsigned cfg_delay = DELAY_RESET;
	int unsigned cfg_volume = FEEDBACK_RESET;
	int unsigned cfg_spread = SPREAD_RESET;
	int unsigned cfg_start = 0;

	int          past_l [MAX_FRAMES];
	int          past_r [MAX_FRAMES];
	int          echo_l [MAX_FRAMES];
	int          echo_r [MAX_FRAMES];
	int unsigned echo_wp;
	int unsigned past_wp;
	int unsigned gain_l;
	int unsigned gain_r;
	bit          fall_l;
	bit          fall_r;
	bit          lead_side;
	int unsigned swap_count;
	int unsigned frame_count;

	frame_t      expected_frames [$];
	stim_row_t   stim_rows [$];
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int clip_sample(input longint v);
		if (v > PEAK_POS) begin
			return PEAK_POS;
		end
		if (v < PEAK_NEG) begin
			return PEAK_NEG;
		end
		return int'(v);
	endfunction

	function automatic longint scale_q16(input int x, input int unsigned g);
		longint p;
		p = longint'(x) * longint'(g) + 64'sd32768;
		return p >>> 16;
	endfunction

	function automatic int unsigned ramp_gain(input int unsigned g, input bit falling);
		if (!falling) begin
			if (g < GAIN_ONE) begin
				g = g + GAIN_STEP;
			end
		end else if (g > cfg_spread) begin
			g = (g > GAIN_STEP) ? g - GAIN_STEP : 0;
		end
		return g;
	endfunction

	task automatic clear_echo_state();
		for (int k = 0; k < MAX_FRAMES; k++) begin
			past_l[k] = 0;
			past_r[k] = 0;
			echo_l[k] = 0;
			echo_r[k] = 0;
		end
		echo_wp = 0;
		past_wp = 0;
		gain_l = 0;
		gain_r = 0;
		fall_l = 1'b0;
		fall_r = 1'b0;
		lead_side = cfg_start[0];
		swap_count = 0;
		frame_count = 0;
	endtask

	task automatic predict_echo_frame(input int l, input int r, input bit last,
			output frame_t res);
		int unsigned f;
		int unsigned d;
		int          ol;
		int          orr;
		d = cfg_delay & 32'h3FFE;
		if (d < 2) begin
			d = 2;
		end
		f = d / 2;
		if (f > MAX_FRAMES) begin
			f = MAX_FRAMES;
		end
		d = 2 * f;
		if (frame_count == 0) begin
			lead_side = cfg_start[0];
		end
		if (echo_wp >= f) begin
			echo_wp = 0;
		end
		if (past_wp >= f) begin
			past_wp = 0;
		end
		if (frame_count > f) begin
			echo_l[echo_wp] = clip_sample(scale_q16(past_l[past_wp], gain_l));
			echo_r[echo_wp] = clip_sample(scale_q16(past_r[past_wp], gain_r));
			echo_wp = (echo_wp + 1) % f;
		end
		gain_l = ramp_gain(gain_l, fall_l);
		gain_r = ramp_gain(gain_r, fall_r);
		if (swap_count > d) begin
			if (lead_side == 1'b0) begin
				lead_side = 1'b1;
				fall_l = 1'b0;
				fall_r = 1'b1;
			end else begin
				lead_side = 1'b0;
				fall_l = 1'b1;
				fall_r = 1'b0;
			end
			swap_count = 0;
		end else begin
			swap_count++;
		end
		ol = clip_sample(longint'(l) + scale_q16(echo_l[echo_wp], cfg_volume));
		orr = clip_sample(longint'(r) + scale_q16(echo_r[echo_wp], cfg_volume));
		past_l[past_wp] = ol;
		past_r[past_wp] = orr;
		past_wp = (past_wp + 1) % f;
		if (frame_count < FRAMES_SAT) begin
			frame_count++;
		end
		res.left = sample_t'(ol);
		res.right = sample_t'(orr);
		if (last) begin
			clear_echo_state();
		end
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d", what, got, want);
		mismatches++;
	endtask

	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (quiet) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 70) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	function automatic int draw_sample();
		sample_t s;
		case ($urandom_range(0, 9))
			0: s = sample_t'(PEAK_POS);
			1: s = sample_t'(PEAK_NEG);
			2: s = sample_t'($urandom_range(0, 511) - 256);
			default: s = sample_t'($urandom());
		endcase
		return int'(s);
	endfunction

	function automatic int unsigned pick_gain();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return GAIN_ONE;
			2: return 131071;
			default: return $urandom_range(0, 65536);
		endcase
	endfunction

	function automatic int unsigned pick_delay();
		case ($urandom_range(0, 9))
			6: return 2048;
			7: return 16383;
			8: return 8192;
			9: return $urandom_range(0, 16383);
			default: return $urandom_range(0, 48);
		endcase
	endfunction

	// The result port stalls at random and, once on request, holds off for a long stretch.
	always @(posedge clk) begin
		frame_t      got;
		frame_t      want;
		int unsigned gap;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (expected_frames.size() == 0) begin
				report_mismatch("word with nothing expected, left", int'(got.left), 0);
			end else begin
				want = expected_frames.pop_front();
				if (got.left !== want.left) begin
					report_mismatch("left_out", int'(got.left), int'(want.left));
				end
				if (got.right !== want.right) begin
					report_mismatch("right_out", int'(got.right), int'(want.right));
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			gap = pick_gap();
			if (gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				hold_left = gap - 1;
				m_tready <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic send_frame(input int l, input int r, input bit last, input bit typed,
			input frame_t typed_want);
		frame_t pred;
		s_tvalid <= 1'b1;
		s_tdata <= {sample_t'(r), sample_t'(l)};
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		predict_echo_frame(l, r, last, pred);
		expected_frames.push_back(typed ? typed_want : pred);
	endtask

	task automatic idle_sender(input int unsigned n);
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_frames.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input spd_reg_t idx, input int unsigned value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		case (idx)
			REG_DELAY:    cfg_delay = value & 32'h3FFF;
			REG_FEEDBACK: cfg_volume = value & 32'h1FFFF;
			REG_SPREAD:   cfg_spread = value & 32'h1FFFF;
			REG_START:    cfg_start = value & 32'h1;
			default:      ;
		endcase
	endtask

	task automatic configure(input int unsigned d, input int unsigned v, input int unsigned s,
			input int unsigned side);
		drain_results();
		write_reg(REG_DELAY, d);
		write_reg(REG_FEEDBACK, v);
		write_reg(REG_SPREAD, s);
		write_reg(REG_START, side);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_frames(input int unsigned count, input int unsigned last_rate);
		frame_t none;
		bit     last;
		none = '0;
		for (int unsigned k = 0; k < count; k++) begin
			last = (last_rate != 0) && ($urandom_range(0, last_rate - 1) == 0);
			send_frame(draw_sample(), draw_sample(), last, 1'b0, none);
			if ($urandom_range(0, 199) == 0) begin
				drain_results();
			end else begin
				idle_sender(pick_gap());
			end
		end
	endtask

	task automatic add_frame(input int l, input int r, input bit last);
		stim_row_t row;
		row = '{idx: REG_DELAY, default: 0};
		row.l = l;
		row.r = r;
		row.last = last;
		stim_rows.push_back(row);
	endtask

	task automatic add_typed(input int l, input int r, input bit last, input int el,
			input int er);
		stim_row_t row;
		row = '{idx: REG_DELAY, default: 0};
		row.l = l;
		row.r = r;
		row.last = last;
		row.typed = 1'b1;
		row.want.left = sample_t'(el);
		row.want.right = sample_t'(er);
		stim_rows.push_back(row);
	endtask

	task automatic add_setting(input spd_reg_t idx, input int unsigned value);
		stim_row_t row;
		row = '{idx: REG_DELAY, default: 0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.value = value;
		stim_rows.push_back(row);
	endtask

	initial begin
		stim_row_t row;
		clear_echo_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// While the ring is still empty after reset, every word passes through unchanged.
		add_typed(0, 0, 1'b0, 0, 0);
		add_typed(PEAK_POS, PEAK_NEG, 1'b0, PEAK_POS, PEAK_NEG);
		add_typed(PEAK_NEG, PEAK_POS, 1'b0, PEAK_NEG, PEAK_POS);
		add_typed(PEAK_POS, PEAK_POS, 1'b0, PEAK_POS, PEAK_POS);
		add_typed(PEAK_NEG, PEAK_NEG, 1'b0, PEAK_NEG, PEAK_NEG);
		add_typed(1, -1, 1'b0, 1, -1);
		add_typed(-1, 1, 1'b1, -1, 1);
		add_typed(5921370, -2775642, 1'b0, 5921370, -2775642);
		add_typed(8388352, -2, 1'b0, 8388352, -2);
		// Shrinking the delay mid-buffer forces the history pointer to wrap.
		add_setting(REG_DELAY, 2);
		add_setting(REG_FEEDBACK, 65536);
		add_frame(PEAK_POS, PEAK_NEG, 1'b0);
		add_frame(PEAK_POS, PEAK_NEG, 1'b0);
		add_frame(PEAK_POS, PEAK_NEG, 1'b0);
		add_frame(0, 0, 1'b0);
		add_frame(-5, 7, 1'b0);
		add_setting(REG_SPREAD, 0);
		add_setting(REG_START, 1);
		add_frame(100, -100, 1'b1);
		add_frame(PEAK_NEG, PEAK_POS, 1'b0);
		add_setting(REG_DELAY, 16383);
		add_setting(REG_FEEDBACK, 131071);
		add_frame(PEAK_POS, PEAK_NEG, 1'b0);
		add_setting(REG_DELAY, 1);
		add_frame(PEAK_NEG, PEAK_POS, 1'b0);
		add_frame(PEAK_NEG, PEAK_POS, 1'b0);

		foreach (stim_rows[k]) begin
			row = stim_rows[k];
			if (row.is_cfg) begin
				drain_results();
				write_reg(row.idx, row.value);
				cfg_valid <= 1'b0;
			end else begin
				send_frame(row.l, row.r, row.last, row.typed, row.want);
				idle_sender(pick_gap());
			end
		end

		// One long buffer lets the gains ramp and swap many times.
		configure(40, 40000, 20000, 0);
		hold_req = 1'b1;
		run_frames(1000, 0);

		for (int unsigned ph = 0; ph < 10; ph++) begin
			configure(pick_delay(), pick_gain(), pick_gain(), $urandom_range(0, 1));
			quiet = (ph % 4 == 1);
			run_frames(50, (ph % 2 == 1) ? 8 : 60);
		end
		quiet = 1'b0;

		drain_results();
		if (expected_frames.size() != 0) begin
			report_mismatch("words never delivered", expected_frames.size(), 0);
		end
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
